[rtl/pbc_pkg.sv]
`default_nettype none
package pbc_pkg;

	localparam int NUM_COMP = 3;
	localparam int COMP_W = 16;

	// register indexes on the configuration port
	localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
	localparam logic [2:0] REG_CONTRAST = 3'd1;
	localparam logic [2:0] REG_LUMA_ONLY = 3'd2;
	localparam logic [2:0] REG_YUV_FORMAT = 3'd3;
	localparam logic [2:0] REG_SIXTEEN_BIT = 3'd4;

	// full scale in both modes
	localparam logic [15:0] FULL_8 = 16'h00ff;
	localparam logic [15:0] FULL_16 = 16'hffff;

	// reciprocals for the divisions by 100 and 25, with their shifts
	localparam logic [12:0] REC100_8 = 13'd5243;      // ceil(2^19 / 100)
	localparam logic [23:0] REC100_16 = 24'd10737419; // ceil(2^30 / 100)
	localparam logic [15:0] REC25 = 16'd41944;        // ceil(2^20 / 25)

	// full * 128, the mid point term of the contrast offset
	localparam logic signed [29:0] MID_8 = 30'sd32640;
	localparam logic signed [29:0] MID_16 = 30'sd8388480;

	// unity gain in signed 4.8
	localparam logic signed [11:0] GAIN_UNITY = 12'sd256;

	typedef struct packed {
		logic [NUM_COMP-1:0][COMP_W-1:0] comp;
		logic [COMP_W-1:0] alpha;
	} pixel_t;

	// settings and the terms derived from them, as seen by the pixel path
	typedef struct packed {
		logic luma_only;
		logic yuv_format;
		logic sixteen_bit;
		logic signed [9:0] boff8;
		logic signed [17:0] boff16;
		logic signed [11:0] gain;
		logic signed [29:0] coff;
	} cfg_t;

	function automatic logic [15:0] full_scale(input logic sixteen);
		return sixteen ? FULL_16 : FULL_8;
	endfunction

endpackage
`default_nettype wire

[rtl/pixel_brightness_contrast.sv]
// Brightness and contrast adjustment, one pixel per request.
//
// Input stream s_axis: tdata carries comp_first, comp_second, comp_third
// and alpha_in, 16 bits each, first field in the low bits. Output stream
// m_axis carries out_first, out_second, out_third and alpha_out the same way.
// Configuration: a write on cfg_valid with cfg_index selecting brightness,
// contrast, luma_only, yuv_format or sixteen_bit; cfg_ready is always high.
// Write settings only while no pixel is in flight.
//
// Three register stages: input register, brightness register and result
// register; a pixel passes through them in that order to m_axis. One pixel
// is taken every cycle while s_axis_tready is high; each stage has its own
// valid flag so a stage empties into the next whenever that one is empty,
// even while the output is held. When the receiver stalls, the result holds
// on m_axis and up to two more pixels are taken before s_axis_tready drops.
// Reset empties the pipeline and restores zero brightness, unity contrast,
// luma-only contrast, RGB pixels and 8-bit full scale.
`default_nettype none
module pixel_brightness_contrast (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [63:0] s_axis_tdata, // comp_first, comp_second, comp_third, alpha_in
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [63:0] m_axis_tdata, // out_first, out_second, out_third, alpha_out
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [7:0] cfg_data
);
	import pbc_pkg::*;

	cfg_t cfg;
	pixel_t pix_in, pix_s2, pix_q;
	logic s1_v_q, s2_v_q, out_v_q;
	logic rdy_out, rdy_s2, rdy_s1;
	logic ld_s1, ld_s2, ld_out;

	assign cfg_ready = 1'b1;

	pbc_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	// stage handshake: a stage loads when empty or when it drains forward
	assign rdy_out = !out_v_q || m_axis_tready;
	assign rdy_s2 = !s2_v_q || rdy_out;
	assign rdy_s1 = !s1_v_q || rdy_s2;
	assign ld_out = s2_v_q && rdy_out;
	assign ld_s2 = s1_v_q && rdy_s2;
	assign ld_s1 = s_axis_tvalid && rdy_s1;
	assign s_axis_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			s1_v_q <= ld_s1 || (s1_v_q && !ld_s2);
			s2_v_q <= ld_s2 || (s2_v_q && !ld_out);
			out_v_q <= ld_out || (out_v_q && !m_axis_tready);
		end
	end

	// tdata field order: components from the low bits, alpha on top
	assign pix_in.comp[0] = s_axis_tdata[15:0];
	assign pix_in.comp[1] = s_axis_tdata[31:16];
	assign pix_in.comp[2] = s_axis_tdata[47:32];
	assign pix_in.alpha = s_axis_tdata[63:48];

	pbc_bright u_bright (
		.clk(clk),
		.ld_s1(ld_s1),
		.ld_s2(ld_s2),
		.pix_in(pix_in),
		.cfg(cfg),
		.pix_s2(pix_s2)
	);

	pbc_contrast u_contrast (
		.clk(clk),
		.ld_out(ld_out),
		.pix_s2(pix_s2),
		.cfg(cfg),
		.pix_q(pix_q)
	);

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {pix_q.alpha, pix_q.comp[2], pix_q.comp[1], pix_q.comp[0]};

endmodule
`default_nettype wire

[rtl/pbc_cfg.sv]
`default_nettype none
module pbc_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic [2:0] cfg_index,
	input wire logic [7:0] cfg_data,
	output pbc_pkg::cfg_t cfg
);
	import pbc_pkg::*;

	logic luma_q, yuv_q, sixteen_q;
	logic signed [9:0] boff8_q;
	logic signed [17:0] boff16_q;
	logic signed [11:0] gain_q;
	logic signed [29:0] coff_q;

	// brightness offset: trunc(p * full / 100) for both full scales
	logic signed [7:0] wr_s;
	logic [7:0] b_mag;
	logic [15:0] b_p8;
	logic [28:0] b_m8;
	logic [23:0] b_p16;
	logic [47:0] b_m16;
	logic [8:0] b_q8;
	logic [16:0] b_q16;
	logic signed [9:0] boff8_d;
	logic signed [17:0] boff16_d;

	assign wr_s = $signed(cfg_data);
	assign b_mag = wr_s[7] ? 8'(-cfg_data) : cfg_data;
	assign b_p8 = {b_mag, 8'd0} - 16'(b_mag);
	assign b_m8 = 29'(b_p8) * 29'(REC100_8);
	assign b_q8 = b_m8[27:19];
	assign b_p16 = {b_mag, 16'd0} - 24'(b_mag);
	assign b_m16 = 48'(b_p16) * 48'(REC100_16);
	assign b_q16 = b_m16[46:30];
	assign boff8_d = wr_s[7] ? -$signed({1'b0, b_q8}) : $signed({1'b0, b_q8});
	assign boff16_d = wr_s[7] ? -$signed({1'b0, b_q16}) : $signed({1'b0, b_q16});

	// contrast gain: (c+100)*256/100 below zero, (c+25)*256/25 otherwise
	logic signed [8:0] g_v;
	logic g_neg;
	logic [7:0] g_mag;
	logic [15:0] g_n;
	logic [31:0] g_m;
	logic [10:0] g_q;
	logic signed [11:0] gain_d;

	assign g_v = wr_s[7] ? ($signed({wr_s[7], cfg_data}) + 9'sd100)
	                     : ($signed({wr_s[7], cfg_data}) + 9'sd25);
	assign g_neg = g_v[8];
	assign g_mag = g_neg ? 8'(-g_v) : g_v[7:0];
	// (c+100)*256/100 is (c+100)*64/25
	assign g_n = wr_s[7] ? {2'd0, g_mag, 6'd0} : {g_mag, 8'd0};
	assign g_m = 32'(g_n) * 32'(REC25);
	assign g_q = g_m[30:20];
	assign gain_d = g_neg ? -$signed({1'b0, g_q}) : $signed({1'b0, g_q});

	// contrast offset from the stored gain: full*128 - trunc(full*gain/2)
	logic signed [28:0] gain_x;
	logic signed [28:0] fg;
	logic signed [28:0] fg_adj;
	logic signed [28:0] half;
	logic signed [29:0] coff_d;

	assign gain_x = {{17{gain_q[11]}}, gain_q};
	assign fg = sixteen_q ? ((gain_x <<< 16) - gain_x) : ((gain_x <<< 8) - gain_x);
	assign fg_adj = fg + $signed({28'd0, fg[28]});
	assign half = fg_adj >>> 1;
	assign coff_d = (sixteen_q ? MID_16 : MID_8) - {half[28], half};

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_q <= 1'b1;
			yuv_q <= 1'b0;
			sixteen_q <= 1'b0;
			boff8_q <= '0;
			boff16_q <= '0;
			gain_q <= GAIN_UNITY;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BRIGHTNESS: begin
					boff8_q <= boff8_d;
					boff16_q <= boff16_d;
				end
				REG_CONTRAST: gain_q <= gain_d;
				REG_LUMA_ONLY: luma_q <= cfg_data[0];
				REG_YUV_FORMAT: yuv_q <= cfg_data[0];
				REG_SIXTEEN_BIT: sixteen_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// offset is registered and follows gain and scale in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coff_q <= '0;
		end else begin
			coff_q <= coff_d;
		end
	end

	assign cfg.luma_only = luma_q;
	assign cfg.yuv_format = yuv_q;
	assign cfg.sixteen_bit = sixteen_q;
	assign cfg.boff8 = boff8_q;
	assign cfg.boff16 = boff16_q;
	assign cfg.gain = gain_q;
	assign cfg.coff = coff_q;

endmodule
`default_nettype wire

[rtl/pbc_bright.sv]
`default_nettype none
module pbc_bright (
	input wire logic clk,
	input wire logic ld_s1,
	input wire logic ld_s2,
	input wire pbc_pkg::pixel_t pix_in,
	input wire pbc_pkg::cfg_t cfg,
	output pbc_pkg::pixel_t pix_s2
);
	import pbc_pkg::*;

	pixel_t pix_s1;
	pixel_t pix_d;
	logic [15:0] full;
	logic signed [17:0] boff;

	assign full = full_scale(cfg.sixteen_bit);
	assign boff = cfg.sixteen_bit ? cfg.boff16 : {{8{cfg.boff8[9]}}, cfg.boff8};

	// mask to the active width, add the offset and clamp (in YUV format only the first component)
	always_comb begin
		logic [15:0] c;
		logic signed [18:0] sum;
		pix_d.alpha = pix_s1.alpha & full;
		for (int i = 0; i < NUM_COMP; i++) begin
			c = pix_s1.comp[i] & full;
			sum = $signed({3'd0, c}) + {boff[17], boff};
			if ((i == 0) || !cfg.yuv_format) begin
				if (sum[18])
					pix_d.comp[i] = '0;
				else if (sum[17:0] > {2'd0, full})
					pix_d.comp[i] = full;
				else
					pix_d.comp[i] = sum[15:0];
			end else begin
				pix_d.comp[i] = c;
			end
		end
	end

	// input register and brightness result register
	always_ff @(posedge clk) begin
		if (ld_s1)
			pix_s1 <= pix_in;
		if (ld_s2)
			pix_s2 <= pix_d;
	end

endmodule
`default_nettype wire

[rtl/pbc_contrast.sv]
`default_nettype none
module pbc_contrast (
	input wire logic clk,
	input wire logic ld_out,
	input wire pbc_pkg::pixel_t pix_s2,
	input wire pbc_pkg::cfg_t cfg,
	output pbc_pkg::pixel_t pix_q
);
	import pbc_pkg::*;

	pixel_t pix_d;
	logic [15:0] full;

	assign full = full_scale(cfg.sixteen_bit);

	// (x * gain + offset) >> 8, floor, then clamp; in luma-only YUV the other two components pass through
	always_comb begin
		logic signed [28:0] prod;
		logic signed [29:0] acc;
		logic signed [21:0] sh;
		pix_d.alpha = pix_s2.alpha;
		for (int i = 0; i < NUM_COMP; i++) begin
			prod = $signed({1'b0, pix_s2.comp[i]}) * cfg.gain;
			acc = {prod[28], prod} + cfg.coff;
			sh = acc[29:8];
			if ((i == 0) || !(cfg.luma_only && cfg.yuv_format)) begin
				if (sh[21])
					pix_d.comp[i] = '0;
				else if (sh[20:0] > {5'd0, full})
					pix_d.comp[i] = full;
				else
					pix_d.comp[i] = sh[15:0];
			end else begin
				pix_d.comp[i] = pix_s2.comp[i];
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ld_out)
			pix_q <= pix_d;
	end

endmodule
`default_nettype wire

[rtl/pbc_checker.sv]
`default_nettype none
module pbc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [63:0] m_axis_tdata,
	input wire logic cfg_valid,
	input wire logic cfg_ready
);

	// a held result keeps its value until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a draining output never blocks the input side
	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input blocked while output drains");

	// an empty output register leaves room for a new request
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output");

	// configuration writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind pixel_brightness_contrast pbc_checker u_pbc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);
`default_nettype wire
